### hdl/esd_pkg.sv
package esd_pkg;

  // input item as seen on the in_ ports
  typedef struct packed {
    logic [7:0] char_in;
    logic       final_byte;
  } in_t;

  // result item as seen on the out_ ports
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       end_of_string;
  } out_t;

  // classified byte passed from the front to the back
  typedef struct packed {
    logic [7:0] raw;
    logic       fin;
    logic       is_bslash;
    logic       esc_ok;
    logic [7:0] esc_byte;
    logic       is_x;
    logic       is_hex;
    logic [3:0] hex_val;
  } cls_t;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_HEX     = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // characters
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // result queue
  localparam int ODEPTH = 2;
  localparam int OAW    = $clog2(ODEPTH);

endpackage

### hdl/esd_front.sv
module esd_front (
  input  esd_pkg::in_t  item,
  output esd_pkg::cls_t cls
);

  logic [7:0] c;

  assign c = item.char_in;

  // classify the raw byte
  always_comb begin
    cls           = '0;
    cls.raw       = c;
    cls.fin       = item.final_byte;
    cls.is_bslash = (c == esd_pkg::CH_BSLASH);
    cls.is_x      = (c == esd_pkg::CH_X);

    // single-letter escapes
    case (c)
      esd_pkg::CH_N: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_LF;
      end
      esd_pkg::CH_R: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_CR;
      end
      esd_pkg::CH_T: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_TAB;
      end
      esd_pkg::CH_DQUOTE: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_DQUOTE;
      end
      esd_pkg::CH_BSLASH: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_BSLASH;
      end
      esd_pkg::CH_ZERO: begin
        cls.esc_ok   = 1'b1;
        cls.esc_byte = esd_pkg::CH_NUL;
      end
      default: begin
        cls.esc_ok   = 1'b0;
        cls.esc_byte = esd_pkg::CH_NUL;
      end
    endcase

    // hex digit value, either case
    if (c inside {[8'h30:8'h39]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = c[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(c - 8'h57);
    end
  end

endmodule

### hdl/esd_queue.sv
module esd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  esd_pkg::cls_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output esd_pkg::cls_t rd_data,
  output logic          empty
);

  esd_pkg::cls_t      mem_r [esd_pkg::QDEPTH];
  logic [esd_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [esd_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [esd_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign full  = (cnt_r == (esd_pkg::QAW+1)'(esd_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

### hdl/esd_back.sv
module esd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  esd_pkg::cls_t cls,
  input  logic          cls_valid,
  output logic          cls_take,
  output esd_pkg::out_t res,
  output logic          res_empty,
  input  logic          res_pop
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_HEX1   = 2'd2;
  localparam logic [1:0] MODE_HEX2   = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic [3:0] hnib_r, hnib_nxt;
  logic       drop_r, drop_nxt;
  logic [1:0] held_r, held_nxt;

  logic       emit;
  logic [7:0] data;
  logic [1:0] err;
  logic [7:0] code;
  logic       res_push;
  esd_pkg::out_t res_item;

  esd_pkg::out_t         obuf_r [esd_pkg::ODEPTH];
  logic [esd_pkg::OAW-1:0] owptr_r, orptr_r;
  logic [esd_pkg::OAW:0]   ocnt_r, ocnt_nxt;
  logic room, do_pop;

  assign room     = (ocnt_r != (esd_pkg::OAW+1)'(esd_pkg::ODEPTH));
  assign cls_take = cls_valid && room;
  assign code     = {hnib_r, cls.hex_val};

  // decode step for the byte at the queue head
  always_comb begin
    emit     = 1'b0;
    data     = 8'h00;
    err      = esd_pkg::ST_OK;
    mode_nxt = mode_r;
    hnib_nxt = hnib_r;
    drop_nxt = drop_r;
    held_nxt = held_r;

    if (drop_r) begin
      err = held_r;
    end else begin
      case (mode_r)
        MODE_NORMAL: begin
          if (cls.is_bslash) begin
            if (cls.fin) err = esd_pkg::ST_UNKNOWN;
            else mode_nxt = MODE_ESC;
          end else begin
            emit = 1'b1;
            data = cls.raw;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_NORMAL;
          if (cls.esc_ok) begin
            emit = 1'b1;
            data = cls.esc_byte;
          end else if (cls.is_x) begin
            if (cls.fin) err = esd_pkg::ST_HEX;
            else mode_nxt = MODE_HEX1;
          end else begin
            err = esd_pkg::ST_UNKNOWN;
          end
        end
        MODE_HEX1: begin
          mode_nxt = MODE_NORMAL;
          if (!cls.is_hex || cls.fin) begin
            err = esd_pkg::ST_HEX;
          end else begin
            hnib_nxt = cls.hex_val;
            mode_nxt = MODE_HEX2;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          hnib_nxt = 4'h0;
          if (!cls.is_hex) begin
            err = esd_pkg::ST_HEX;
          end else if (code[7]) begin
            err = esd_pkg::ST_RANGE;
          end else begin
            emit = 1'b1;
            data = code;
          end
        end
      endcase

      // first error starts dropping
      if (err != esd_pkg::ST_OK) begin
        drop_nxt = 1'b1;
        held_nxt = err;
        emit     = 1'b0;
        data     = 8'h00;
      end
    end

    // final byte closes the string and clears state
    if (cls.fin) begin
      mode_nxt = MODE_NORMAL;
      hnib_nxt = 4'h0;
      drop_nxt = 1'b0;
      held_nxt = esd_pkg::ST_OK;
    end

    res_item.data_byte     = data;
    res_item.has_byte      = emit;
    res_item.status        = cls.fin ? err : esd_pkg::ST_OK;
    res_item.end_of_string = cls.fin;
    res_push               = cls_take && (emit || cls.fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      hnib_r <= 4'h0;
      drop_r <= 1'b0;
      held_r <= esd_pkg::ST_OK;
    end else if (cls_take) begin
      mode_r <= mode_nxt;
      hnib_r <= hnib_nxt;
      drop_r <= drop_nxt;
      held_r <= held_nxt;
    end
  end

  // result queue
  assign res_empty = (ocnt_r == '0);
  assign do_pop    = res_pop && !res_empty;
  assign res       = obuf_r[orptr_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_push && !do_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (do_pop && !res_push) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (res_push) owptr_r <= owptr_r + 1'b1;
      if (do_pop) orptr_r <= orptr_r + 1'b1;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      obuf_r[owptr_r] <= res_item;
    end
  end

endmodule

### hdl/escape_sequence_decoder_core.sv
// a pushed byte is registered in the classify queue, decoded from the queue head, and its result
// is registered in the result queue, from which it is popped
// throughput: one byte per cycle while the result queue has room
// bytes that complete nothing or are dropped after an error give no result, but a final byte always gives one
// reset: synchronous active-low rst_n empties both queues and clears the decoder
module escape_sequence_decoder_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  esd_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output esd_pkg::out_t out_data
);

  esd_pkg::cls_t cls_in, cls_head;
  logic          q_empty, q_take;

  // front: classify incoming byte
  esd_front u_front (
    .item (in_data),
    .cls  (cls_in)
  );

  // queue between classify and decode
  esd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (cls_in),
    .full    (in_full),
    .rd_en   (q_take),
    .rd_data (cls_head),
    .empty   (q_empty)
  );

  // back: decode state machine and result queue
  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (cls_head),
    .cls_valid (!q_empty),
    .cls_take  (q_take),
    .res       (out_data),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

endmodule

### sim/esd_decode_checker.sv
`timescale 1ns / 1ps

module esd_decode_checker
  import esd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  logic in_full,
  input  in_t  in_data,
  input  logic out_empty,
  input  logic out_pop,
  input  out_t out_data,
  output int   errors,
  output int   pending,
  output int   checked
);

  typedef enum logic [1:0] {
    M_PLAIN,
    M_ESC,
    M_HEX_HI,
    M_HEX_LO
  } mode_e;

  // decoder state as predicted
  mode_e      mode;
  logic [3:0] hi_nib;
  logic       dropping;
  logic [1:0] held_err;

  // decoded results still to come out of the block
  out_t decoded_q[$];

  // hex digit of either case to its value
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic ok;
    v  = 4'd0;
    ok = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v  = c[3:0];
      ok = 1'b1;
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v  = c[3:0] + 4'd9;
      ok = 1'b1;
    end
    return ok;
  endfunction

  task automatic clear_decoder();
    mode     = M_PLAIN;
    hi_nib   = 4'd0;
    dropping = 1'b0;
    held_err = ST_OK;
  endtask

  // advance the predicted decoder by one byte, queue the result it causes
  task automatic decode_byte(input in_t b);
    logic       emit;
    logic [7:0] val;
    logic [1:0] err;
    logic [3:0] nib;
    logic       ok;
    out_t       r;
    emit = 1'b0;
    val  = 8'd0;
    err  = ST_OK;
    if (dropping) begin
      err = held_err;
    end else begin
      case (mode)
        M_PLAIN: begin
          if (b.char_in == CH_BSLASH) begin
            if (b.final_byte) err = ST_UNKNOWN;
            else mode = M_ESC;
          end else begin
            emit = 1'b1;
            val  = b.char_in;
          end
        end
        M_ESC: begin
          mode = M_PLAIN;
          emit = 1'b1;
          case (b.char_in)
            CH_N:      val = CH_LF;
            CH_R:      val = CH_CR;
            CH_T:      val = CH_TAB;
            CH_DQUOTE: val = CH_DQUOTE;
            CH_BSLASH: val = CH_BSLASH;
            CH_ZERO:   val = CH_NUL;
            CH_X: begin
              emit = 1'b0;
              if (b.final_byte) err = ST_HEX;
              else mode = M_HEX_HI;
            end
            default: begin
              emit = 1'b0;
              err  = ST_UNKNOWN;
            end
          endcase
        end
        M_HEX_HI: begin
          mode = M_PLAIN;
          ok   = hex_nibble(b.char_in, nib);
          if (!ok || b.final_byte) begin
            err = ST_HEX;
          end else begin
            hi_nib = nib;
            mode   = M_HEX_LO;
          end
        end
        default: begin
          mode = M_PLAIN;
          ok   = hex_nibble(b.char_in, nib);
          if (!ok) begin
            err = ST_HEX;
          end else if ({hi_nib, nib} > 8'h7f) begin
            err = ST_RANGE;
          end else begin
            emit = 1'b1;
            val  = {hi_nib, nib};
          end
          hi_nib = 4'd0;
        end
      endcase
      // first error: hold it and drop the rest of the string
      if (err != ST_OK) begin
        dropping = 1'b1;
        held_err = err;
        emit     = 1'b0;
        val      = 8'd0;
      end
    end

    if (b.final_byte) begin
      r.data_byte     = emit ? val : 8'd0;
      r.has_byte      = emit;
      r.status        = err;
      r.end_of_string = 1'b1;
      decoded_q.push_back(r);
      clear_decoder();
    end else if (emit) begin
      r.data_byte     = val;
      r.has_byte      = 1'b1;
      r.status        = ST_OK;
      r.end_of_string = 1'b0;
      decoded_q.push_back(r);
    end
  endtask

  // compare one popped result with the oldest prediction
  task automatic check_result(input out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: data_byte %02h has_byte %0b status %0d end_of_string %0b",
             got.data_byte, got.has_byte, got.status, got.end_of_string);
      errors++;
    end else begin
      want = decoded_q.pop_front();
      checked++;
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.end_of_string !== want.end_of_string) begin
        $error("end_of_string: expected %0b, got %0b", want.end_of_string, got.end_of_string);
        errors++;
      end
    end
  endtask

  // watch both channels at each edge, results first
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      decoded_q.delete();
    end else begin
      if (out_pop && !out_empty) check_result(out_data);
      if (in_push && !in_full) decode_byte(in_data);
    end
    pending = decoded_q.size();
  end

endmodule

### sim/tb_escape_sequence_decoder_core.sv
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_core;
  import esd_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t  in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;

  int errors;
  int pending;
  int checked;

  int         bytes_sent;
  int         strings_sent;
  int         cycle_cnt;
  bit         quiet;
  logic [7:0] text_q[$];

  escape_sequence_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  esd_decode_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = 8'h30 + v;
    else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + (v - 4'd10);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66));
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] simple_letter();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = CH_N;
      1:       c = CH_R;
      2:       c = CH_T;
      3:       c = CH_DQUOTE;
      4:       c = CH_BSLASH;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] unknown_letter();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c inside {CH_N, CH_R, CH_T, CH_DQUOTE, CH_BSLASH, CH_ZERO, CH_X});
    return c;
  endfunction

  // one byte transfer, then an optional gap
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    in_push <= 1'b1;
    in_data <= '{char_in: c, final_byte: fin};
    do @(posedge clk);
    while (in_full);
    bytes_sent++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random string: mostly plain bytes and well-formed escapes, some broken ones, some noise
  task automatic build_text();
    int         tokens;
    int         pick;
    logic [3:0] hi;
    text_q.delete();
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    if ($urandom_range(0, 99) < 8) begin
      // raw noise, heavy on backslashes
      repeat (tokens) text_q.push_back($urandom_range(0, 3) == 0 ? CH_BSLASH : 8'($urandom));
    end else begin
      repeat (tokens) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          text_q.push_back(plain_char());
        end else if (pick < 70) begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(simple_letter());
        end else if (pick < 88) begin
          hi = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15))
                                            : 4'($urandom_range(0, 7));
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_X);
          text_q.push_back(hex_char(hi));
          text_q.push_back(hex_char(4'($urandom)));
        end else if (pick < 94) begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(unknown_letter());
        end else begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_X);
          if ($urandom_range(0, 1)) text_q.push_back(hex_char(4'($urandom)));
          text_q.push_back(non_hex_char());
        end
      end
      // sometimes the string ends inside an escape
      pick = $urandom_range(0, 9);
      if (pick < 3) text_q.push_back(CH_BSLASH);
      if (pick == 1 || pick == 2) text_q.push_back(CH_X);
      if (pick == 2) text_q.push_back(hex_char(4'($urandom)));
    end
  endtask

  // result side: random pop stalls and bursts
  initial begin
    int stall;
    int burst;
    out_pop = 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      repeat (burst) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    quiet   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // simple escapes and byte extremes, ending on an escape
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_N, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_R, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_T, 1'b0);
    send_byte(8'h00, 1'b0);     send_byte(8'hff, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_ZERO, 1'b1);
    // largest legal hex code, then one out of range on the final byte
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_X, 1'b0);
    send_byte(8'h37, 1'b0);     send_byte(8'h66, 1'b0);
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_X, 1'b0);
    send_byte(8'h41, 1'b0);     send_byte(8'h30, 1'b1);
    // unknown escape, then a dropped byte closes the string
    send_byte(CH_BSLASH, 1'b0); send_byte(8'h71, 1'b0);
    send_byte(8'h7a, 1'b1);
    // trailing backslash
    send_byte(CH_BSLASH, 1'b1);
    // string ends right after the x
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_X, 1'b1);
    // non-hex second digit
    send_byte(CH_BSLASH, 1'b0); send_byte(CH_X, 1'b0);
    send_byte(8'h34, 1'b0);     send_byte(8'h67, 1'b1);
    strings_sent = 6;

    // random strings, some of them without any gaps
    while (bytes_sent < RANDOM_BYTES) begin
      build_text();
      quiet = ($urandom_range(0, 3) == 0);
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      strings_sent++;
    end
    in_push <= 1'b0;

    // drain, then allow for the pipeline
    do @(negedge clk);
    while (pending != 0);
    repeat (8) @(negedge clk);

    $display("%0d bytes in %0d strings, plain, escaped, hex and broken", bytes_sent, strings_sent);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
